// ===== hw/rtl/bopp_pkg.sv =====
// Shared constants, types and helpers for the barrier option path payoff unit.
`timescale 1ns / 1ps

package bopp_pkg;

    // Fixed point format of log prices and step counter width
    localparam int FRAC_BITS        = 24;
    localparam int STEP_COUNT_WIDTH = 16;

    // Field and register widths
    localparam int LOG_W    = 32;
    localparam int PRICE_W  = 32;
    localparam int STEPS_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 32;

    // Path length compare width: holds the register value and the counter cap
    localparam int LIM_W = ((STEP_COUNT_WIDTH > STEPS_W) ? STEP_COUNT_WIDTH : STEPS_W) + 1;

    // Exponential: y = x * log2(e) has FRAC_BITS + 30 fraction bits
    localparam int EXP_SHIFT = FRAC_BITS + 30;
    localparam int N_W       = 64 - EXP_SHIFT;   // integer part of y
    localparam int NX_W      = N_W + 8;          // integer part with headroom for compares

    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
    localparam logic [31:0] LN2_Q31   = 32'd1488522236;
    localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
    localparam logic [3:0]  TAYLOR_TERMS = 4'd13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_LOG   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LOG   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LOG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIKE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS       = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_Y,
        S_YSIGN,
        S_MUL_Z,
        S_ZGET,
        S_H_MUL,
        S_H_LOAD,
        S_H_DIV,
        S_H_ACC,
        S_SCALE,
        S_PAY,
        S_OUT
    } state_t;

endpackage

// ===== hw/rtl/barrier_option_path_payoff_unit.sv =====
// Double-barrier knock-out call path walker with fixed point exponential payoff.
`timescale 1ns / 1ps

// Usage:
//  - s_axis carries one scaled Gaussian log increment per beat (Q8.24).
//    Every beat advances the current path by one step: drift plus increment,
//    then an upper/lower barrier test on the exact sum.
//  - A beat that is not the last step of a path produces nothing and leaves
//    the unit ready for the next beat. The last step of a path yields one m_axis beat with
//    the payoff (Q16.16, saturating) in tdata and the survived flag in tuser.
//  - Last step of a live path: the exponential runs through one shared 32x32
//    multiplier and a radix-2 divider: form y and z, then 13 Horner terms
//    (multiply, load, 32 divide steps, accumulate), then scale, payoff and
//    output load. A knocked-out path goes straight to the output load; a
//    price far above range saturates without running the Horner terms.
//  - s_axis_tready is low while the payoff is being computed and while the
//    result waits to enter the output register. The result sits in an output register; the next path may start while it
//    waits. If m_axis stalls and another path ends, the second result is held
//    until the first beat is taken.
//  - Configuration writes through cfg_we/cfg_index/cfg_data are registered and take effect in the next cycle.
//  - Reset returns the configuration and control registers to their defaults and starts a fresh path.
module barrier_option_path_payoff_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bopp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bopp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bopp_pkg::LOG_W-1:0]     s_axis_tdata,   // [31:0] increment
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bopp_pkg::PRICE_W-1:0]   m_axis_tdata,   // [31:0] payoff
    output logic                          m_axis_tuser    // [0] survived
);
    import bopp_pkg::*;

    // configuration
    logic signed [LOG_W-1:0] start_reg, upper_reg, lower_reg, drift_reg;
    logic [PRICE_W-1:0]      strike_reg;
    logic [STEPS_W-1:0]      steps_reg;

    // path state
    state_t state_reg, state_next;
    logic signed [LOG_W-1:0]      log_price_reg;
    logic [STEP_COUNT_WIDTH-1:0]  step_idx_reg;
    logic                         alive_reg;

    // exponential datapath
    logic [63:0]            prod_reg;
    logic [31:0]            mul_a, mul_b;
    logic signed [N_W-1:0]  n_reg;
    logic [31:0]            f_reg, z_reg, r_reg, quo_reg;
    logic [3:0]             k_reg, rem_reg;
    logic [4:0]             div_cnt_reg;
    logic [47:0]            e_reg;
    logic [PRICE_W-1:0]     pay_reg;
    logic                   surv_reg;

    // output register
    logic                   out_valid_reg;
    logic [PRICE_W-1:0]     out_pay_reg;
    logic                   out_surv_reg;
    logic                   out_load;

    // ---------------- step datapath ----------------
    logic                    path_start, alive_in, hit, alive_fin, last_step, in_fire;
    logic signed [LOG_W-1:0] base;
    logic signed [33:0]      sum_x;
    logic signed [LOG_W-1:0] sat_x, lp_fin;
    logic [LIM_W-1:0]        limit, done_cnt;

    always_comb
    begin
        path_start = (step_idx_reg == '0);
        base       = path_start ? start_reg : log_price_reg;
        alive_in   = path_start | alive_reg;
        sum_x      = 34'(base) + 34'(drift_reg) + 34'($signed(s_axis_tdata));
        hit        = (sum_x >= 34'(upper_reg)) || (sum_x <= 34'(lower_reg));
        if (sum_x[33:31] == 3'b000 || sum_x[33:31] == 3'b111)
            sat_x = sum_x[31:0];
        else
            sat_x = sum_x[33] ? {1'b1, {(LOG_W-1){1'b0}}} : {1'b0, {(LOG_W-1){1'b1}}};
        lp_fin    = alive_in ? sat_x : base;
        alive_fin = alive_in & ~hit;

        limit = (steps_reg == '0) ? LIM_W'(1) : LIM_W'(steps_reg);
        if (limit > (LIM_W'(1) << STEP_COUNT_WIDTH))
            limit = LIM_W'(1) << STEP_COUNT_WIDTH;
        done_cnt  = LIM_W'(step_idx_reg) + LIM_W'(1);
        last_step = (done_cnt >= limit);
        in_fire   = s_axis_tvalid & s_axis_tready;
    end

    // ---------------- scale and payoff ----------------
    logic signed [NX_W-1:0] n_ext, n_m15, rs;
    logic                   n_sat;
    logic [5:0]             rs6;
    logic [33:0]            r_rnd;
    logic [47:0]            e_val;
    logic [47:0]            diff;
    logic [63:0]            y;
    logic [4:0]             div_trial;
    logic                   div_bit;

    always_comb
    begin
        y      = log_price_reg[LOG_W-1] ? (~prod_reg + 64'd1) : prod_reg;
        n_ext  = NX_W'(n_reg);
        n_sat  = (n_ext >= $signed(NX_W'(32)));
        n_m15  = n_ext - $signed(NX_W'(15));
        rs     = -n_m15;
        rs6    = rs[5:0];
        r_rnd  = 34'(r_reg) + (34'(1) << (rs6 - 6'd1));
        if (!n_m15[NX_W-1])
            e_val = 48'(r_reg) << n_m15[4:0];
        else if (rs >= $signed(NX_W'(33)))
            e_val = '0;
        else
            e_val = 48'(r_rnd >> rs6);
        diff = e_reg - 48'(strike_reg);

        div_trial = {rem_reg, quo_reg[31]};
        div_bit   = (div_trial >= {1'b0, k_reg});
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_fire && last_step)
                    state_next = alive_fin ? S_MUL_Y : S_OUT;
            S_MUL_Y:  state_next = S_YSIGN;
            S_YSIGN:  state_next = S_MUL_Z;
            S_MUL_Z:  state_next = S_ZGET;
            S_ZGET:   state_next = n_sat ? S_OUT : S_H_MUL;
            S_H_MUL:  state_next = S_H_LOAD;
            S_H_LOAD: state_next = S_H_DIV;
            S_H_DIV:
                if (div_cnt_reg == 5'd31)
                    state_next = S_H_ACC;
            S_H_ACC:  state_next = (k_reg == 4'd1) ? S_SCALE : S_H_MUL;
            S_SCALE:  state_next = S_PAY;
            S_PAY:    state_next = S_OUT;
            S_OUT:
                if (!out_valid_reg || m_axis_tready)
                    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        mul_a         = r_reg;
        mul_b         = z_reg;
        case (state_reg)
            S_IDLE:  s_axis_tready = 1'b1;
            S_MUL_Y:
            begin
                mul_a = log_price_reg[LOG_W-1] ? (~log_price_reg + 32'd1) : log_price_reg;
                mul_b = LOG2E_Q30;
            end
            S_MUL_Z:
            begin
                mul_a = f_reg;
                mul_b = LN2_Q31;
            end
            S_OUT:   out_load = !out_valid_reg || m_axis_tready;
            default:
            begin
                mul_a = r_reg;
                mul_b = z_reg;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            upper_reg  <= {1'b0, {(LOG_W-1){1'b1}}};
            lower_reg  <= {1'b1, {(LOG_W-1){1'b0}}};
            drift_reg  <= '0;
            strike_reg <= '0;
            steps_reg  <= STEPS_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_LOG: start_reg  <= cfg_data;
                REG_UPPER_LOG: upper_reg  <= cfg_data;
                REG_LOWER_LOG: lower_reg  <= cfg_data;
                REG_DRIFT:     drift_reg  <= cfg_data;
                REG_STRIKE:    strike_reg <= cfg_data;
                REG_STEPS:     steps_reg  <= cfg_data[STEPS_W-1:0];
                default:       ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            log_price_reg <= '0;
            step_idx_reg  <= '0;
            alive_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            k_reg         <= TAYLOR_TERMS;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                log_price_reg <= lp_fin;
                alive_reg     <= alive_fin;
                step_idx_reg  <= last_step ? '0 : done_cnt[STEP_COUNT_WIDTH-1:0];
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_ZGET)
                k_reg <= TAYLOR_TERMS;
            else if (state_reg == S_H_ACC)
                k_reg <= k_reg - 4'd1;
            if (state_reg == S_H_DIV)
                div_cnt_reg <= div_cnt_reg + 5'd1;
            else
                div_cnt_reg <= '0;
        end
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        case (state_reg)
            S_IDLE:
                if (in_fire && last_step && !alive_fin)
                begin
                    pay_reg  <= '0;
                    surv_reg <= 1'b0;
                end
            S_YSIGN:
            begin
                n_reg <= y[63:EXP_SHIFT];
                f_reg <= y[EXP_SHIFT-1 -: 32];
            end
            S_ZGET:
            begin
                z_reg    <= prod_reg[63:32];
                r_reg    <= ONE_Q31;
                pay_reg  <= {PRICE_W{1'b1}};
                surv_reg <= 1'b1;
            end
            S_H_LOAD:
            begin
                quo_reg <= prod_reg[62:31];
                rem_reg <= '0;
            end
            S_H_DIV:
            begin
                rem_reg <= div_bit ? 4'(div_trial - {1'b0, k_reg}) : div_trial[3:0];
                quo_reg <= {quo_reg[30:0], div_bit};
            end
            S_H_ACC:  r_reg <= ONE_Q31 + quo_reg;
            S_SCALE:  e_reg <= e_val;
            S_PAY:
            begin
                if (e_reg <= 48'(strike_reg))
                    pay_reg <= '0;
                else
                    pay_reg <= (|diff[47:32]) ? {PRICE_W{1'b1}} : diff[31:0];
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_pay_reg  <= pay_reg;
            out_surv_reg <= surv_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pay_reg;
    assign m_axis_tuser  = out_surv_reg;

    // Horner counter stays within the series length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_H_MUL) |-> (k_reg >= 4'd1 && k_reg <= TAYLOR_TERMS))
        else $error("Horner term index out of range");

    // 2^f is never below one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCALE) |-> (r_reg >= ONE_Q31))
        else $error("exponential mantissa below one");

    // knocked-out paths pay nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("knocked-out path with nonzero payoff");

    // a loaded result shows up on the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_axis_tvalid && state_reg == S_IDLE))
        else $error("result load lost");

endmodule
